### design/vna_pkg.sv
package vna_pkg;

    // field widths
    localparam int IDX_W      = 16;
    localparam int POS_W      = 16;
    localparam int ACC_W      = 24;
    localparam int UNIT_W     = 16;
    localparam int CMD_W      = 2;

    // stream word widths
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 128;
    localparam int RES_W      = 3 * POS_W + 3 * ACC_W + 1;

    // normal datapath widths
    localparam int EDGE_W     = 17;
    localparam int PROD_W     = 34;
    localparam int CROSS_W    = 35;
    localparam int MAG_W      = 34;
    localparam int NMAG_W     = 30;
    localparam int SQ_W       = 60;
    localparam int ROOT_W     = 63;
    localparam int LEN_W      = 31;
    localparam int NUM_W      = 46;
    localparam int QUO_W      = 15;
    localparam int UNIT_SHIFT = 14;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FACE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_FACE,
        OP_READ,
        OP_READ_ZERO
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_first;
        logic [IDX_W-1:0]        corner_second;
        logic [IDX_W-1:0]        corner_third;
    } item_t;

    // result word, pos_x in the lowest bits
    typedef struct packed {
        logic                    saturated;
        logic signed [ACC_W-1:0] normal_z;
        logic signed [ACC_W-1:0] normal_y;
        logic signed [ACC_W-1:0] normal_x;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } result_t;

    typedef struct packed {
        logic                     start;
        logic signed [EDGE_W-1:0] e1x;
        logic signed [EDGE_W-1:0] e1y;
        logic signed [EDGE_W-1:0] e1z;
        logic signed [EDGE_W-1:0] e2x;
        logic signed [EDGE_W-1:0] e2y;
        logic signed [EDGE_W-1:0] e2z;
    } norm_req_t;

    typedef struct packed {
        logic                     done;
        logic                     degenerate;
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
    } norm_res_t;

    typedef enum logic [3:0] {
        N_IDLE,
        N_MUL,
        N_MAG,
        N_MAX,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIVLD,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC,
        B_RD_DATA,
        B_FA,
        B_NORM_GO,
        B_NORM_WAIT,
        B_ACC_RD,
        B_ACC_WR
    } back_state_t;

endpackage

### design/vna_ram.sv
module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/vna_front.sv
module vna_front #(
    parameter int STORE_DEPTH = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vna_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [vna_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          clearing,
    output logic                          q_valid,
    output vna_pkg::item_t                q_item,
    input  logic                          q_pop
);

    localparam int PTR_W = $clog2(vna_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vna_pkg::QUEUE_DEPTH + 1);
    localparam logic [vna_pkg::IDX_W:0] LIMIT = (vna_pkg::IDX_W + 1)'(STORE_DEPTH);

    vna_pkg::item_t    item;
    logic              keep;
    logic              push;
    logic              vi_ok;
    logic              face_ok;

    vna_pkg::item_t    q_mem [vna_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    // classify
    always_comb
    begin
        item.vertex_index  = s_tdata[15:0];
        item.pos_x         = s_tdata[31:16];
        item.pos_y         = s_tdata[47:32];
        item.pos_z         = s_tdata[63:48];
        item.corner_first  = s_tdata[79:64];
        item.corner_second = s_tdata[95:80];
        item.corner_third  = s_tdata[111:96];
        vi_ok   = {1'b0, item.vertex_index} < LIMIT;
        face_ok = ({1'b0, item.corner_first} < LIMIT) &&
                  ({1'b0, item.corner_second} < LIMIT) &&
                  ({1'b0, item.corner_third} < LIMIT);
        keep    = 1'b0;
        item.op = vna_pkg::OP_WRITE;
        unique case (s_tuser)
            vna_pkg::CMD_WRITE:
            begin
                item.op = vna_pkg::OP_WRITE;
                keep    = vi_ok;
            end
            vna_pkg::CMD_FACE:
            begin
                item.op = vna_pkg::OP_FACE;
                keep    = face_ok;
            end
            vna_pkg::CMD_READ:
            begin
                item.op = vi_ok ? vna_pkg::OP_READ : vna_pkg::OP_READ_ZERO;
                keep    = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !clearing && (count_reg != CNT_W'(vna_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = count_reg != '0;
    assign q_item   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### design/vna_norm.sv
module vna_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vna_pkg::norm_req_t   req,
    output vna_pkg::norm_res_t   res
);

    vna_pkg::norm_state_t state_reg, state_next;

    logic signed [vna_pkg::EDGE_W-1:0]  e1_reg [3];
    logic signed [vna_pkg::EDGE_W-1:0]  e2_reg [3];
    logic signed [vna_pkg::PROD_W-1:0]  prod_reg;
    logic signed [vna_pkg::CROSS_W-1:0] cr_reg [3];
    logic [vna_pkg::MAG_W-1:0]          mag_reg [3];
    logic                               neg_reg [3];
    logic [vna_pkg::MAG_W-1:0]          m_reg;
    logic                               degenerate_reg;
    logic [vna_pkg::SQ_W-1:0]           sq_reg;
    logic [vna_pkg::ROOT_W-1:0]         v_reg;
    logic [vna_pkg::ROOT_W-1:0]         root_reg;
    logic [vna_pkg::ROOT_W-1:0]         bit_reg;
    logic [vna_pkg::NUM_W-1:0]          rem_reg;
    logic [vna_pkg::NUM_W-1:0]          div_reg;
    logic [vna_pkg::QUO_W-1:0]          q_reg;
    logic signed [vna_pkg::UNIT_W-1:0]  unit_reg [3];
    logic [4:0]                         cnt_reg;
    logic [1:0]                         comp_reg;

    logic signed [vna_pkg::EDGE_W-1:0]  mul_a, mul_b;
    logic signed [vna_pkg::PROD_W-1:0]  prod;
    logic [2:0]                         fold;
    logic [vna_pkg::MAG_W-1:0]          mx;
    logic [vna_pkg::NMAG_W-1:0]         sq_in;
    logic [vna_pkg::SQ_W-1:0]           sq;
    logic [vna_pkg::ROOT_W-1:0]         trial;
    logic                               root_ge;
    logic [vna_pkg::LEN_W-1:0]          len;
    logic [vna_pkg::NMAG_W-1:0]         div_mag;
    logic                               div_neg;
    logic                               div_ge;
    logic [vna_pkg::QUO_W-1:0]          q_bits;
    logic signed [vna_pkg::UNIT_W-1:0]  q_signed;
    logic                               norm_ok;

    // shared cross product multiplier, one partial product a cycle
    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            default: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign fold = cnt_reg[2:0] - 3'd1;

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
    end

    assign norm_ok = !(|m_reg[vna_pkg::MAG_W-1:vna_pkg::NMAG_W]) && m_reg[vna_pkg::NMAG_W-1];

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    sq_in = mag_reg[0][vna_pkg::NMAG_W-1:0];
            2'd1:    sq_in = mag_reg[1][vna_pkg::NMAG_W-1:0];
            default: sq_in = mag_reg[2][vna_pkg::NMAG_W-1:0];
        endcase
    end

    assign sq      = sq_in * sq_in;
    assign trial   = root_reg + bit_reg;
    assign root_ge = v_reg >= trial;
    assign len     = root_reg[vna_pkg::LEN_W-1:0];

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    begin div_mag = mag_reg[0][vna_pkg::NMAG_W-1:0]; div_neg = neg_reg[0]; end
            2'd1:    begin div_mag = mag_reg[1][vna_pkg::NMAG_W-1:0]; div_neg = neg_reg[1]; end
            default: begin div_mag = mag_reg[2][vna_pkg::NMAG_W-1:0]; div_neg = neg_reg[2]; end
        endcase
    end

    assign div_ge   = rem_reg >= div_reg;
    assign q_bits   = {q_reg[vna_pkg::QUO_W-2:0], div_ge};
    assign q_signed = $signed({1'b0, q_bits});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vna_pkg::N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res.done       = 1'b0;
        res.degenerate = degenerate_reg;
        res.ux         = unit_reg[0];
        res.uy         = unit_reg[1];
        res.uz         = unit_reg[2];
        unique case (state_reg)
            vna_pkg::N_IDLE:  if (req.start) state_next = vna_pkg::N_MUL;
            vna_pkg::N_MUL:   if (cnt_reg == 5'd6) state_next = vna_pkg::N_MAG;
            vna_pkg::N_MAG:   state_next = vna_pkg::N_MAX;
            vna_pkg::N_MAX:   state_next = (mx == '0) ? vna_pkg::N_DONE : vna_pkg::N_SHIFT;
            vna_pkg::N_SHIFT: if (norm_ok) state_next = vna_pkg::N_SQ;
            vna_pkg::N_SQ:    if (cnt_reg == 5'd3) state_next = vna_pkg::N_SQRT;
            vna_pkg::N_SQRT:  if (cnt_reg == 5'd31) state_next = vna_pkg::N_DIVLD;
            vna_pkg::N_DIVLD: state_next = vna_pkg::N_DIV;
            vna_pkg::N_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (comp_reg == 2'd2) ? vna_pkg::N_DONE : vna_pkg::N_DIVLD;
                end
            end
            vna_pkg::N_DONE:
            begin
                res.done   = 1'b1;
                state_next = vna_pkg::N_IDLE;
            end
            default:          state_next = vna_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            vna_pkg::N_IDLE:
            begin
                e1_reg[0] <= req.e1x;
                e1_reg[1] <= req.e1y;
                e1_reg[2] <= req.e1z;
                e2_reg[0] <= req.e2x;
                e2_reg[1] <= req.e2y;
                e2_reg[2] <= req.e2z;
                cnt_reg   <= '0;
            end
            vna_pkg::N_MUL:
            begin
                prod_reg <= prod;
                // fold the previous product: even ones load, odd ones subtract
                if (cnt_reg != '0)
                begin
                    if (!fold[0])
                    begin
                        cr_reg[fold[2:1]] <= vna_pkg::CROSS_W'(prod_reg);
                    end
                    else
                    begin
                        cr_reg[fold[2:1]] <= cr_reg[fold[2:1]] - vna_pkg::CROSS_W'(prod_reg);
                    end
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            vna_pkg::N_MAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= cr_reg[k] < 0;
                    mag_reg[k] <= (cr_reg[k] < 0) ? vna_pkg::MAG_W'(-cr_reg[k])
                                                  : vna_pkg::MAG_W'(cr_reg[k]);
                end
            end
            vna_pkg::N_MAX:
            begin
                m_reg          <= mx;
                degenerate_reg <= mx == '0;
            end
            vna_pkg::N_SHIFT:
            begin
                // one bit a cycle until the largest sits in [2^29, 2^30)
                if (|m_reg[vna_pkg::MAG_W-1:vna_pkg::NMAG_W])
                begin
                    m_reg <= m_reg >> 1;
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end
                else if (!m_reg[vna_pkg::NMAG_W-1])
                begin
                    m_reg <= m_reg << 1;
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= mag_reg[k] << 1;
                    end
                end
                cnt_reg <= '0;
                v_reg   <= '0;
            end
            vna_pkg::N_SQ:
            begin
                sq_reg <= sq;
                if (cnt_reg != '0)
                begin
                    v_reg <= v_reg + vna_pkg::ROOT_W'(sq_reg);
                end
                if (cnt_reg == 5'd3)
                begin
                    root_reg <= '0;
                    bit_reg  <= vna_pkg::ROOT_W'(1) << (vna_pkg::ROOT_W - 1);
                    cnt_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            vna_pkg::N_SQRT:
            begin
                if (root_ge)
                begin
                    v_reg    <= v_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= cnt_reg + 5'd1;
                comp_reg <= '0;
            end
            vna_pkg::N_DIVLD:
            begin
                rem_reg <= vna_pkg::NUM_W'({div_mag, {vna_pkg::UNIT_SHIFT{1'b0}}})
                         + vna_pkg::NUM_W'(len >> 1);
                div_reg <= vna_pkg::NUM_W'(len) << (vna_pkg::QUO_W - 1);
                q_reg   <= '0;
                cnt_reg <= 5'(vna_pkg::QUO_W - 1);
            end
            vna_pkg::N_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - div_reg;
                end
                div_reg <= div_reg >> 1;
                q_reg   <= q_bits;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    unit_reg[comp_reg] <= div_neg ? -q_signed : q_signed;
                    comp_reg           <= comp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### design/vna_back.sv
module vna_back #(
    parameter int STORE_DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  vna_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              clearing,
    output logic              out_valid,
    input  logic              out_ready,
    output vna_pkg::result_t  out_word
);

    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int POS_RAM_W = 3 * vna_pkg::POS_W;
    localparam int ACC_RAM_W = 3 * vna_pkg::ACC_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    vna_pkg::back_state_t state_reg, state_next;

    vna_pkg::item_t                     item_reg;
    logic [1:0]                         cnt_reg;
    logic [ADDR_W-1:0]                  clr_reg;
    logic signed [vna_pkg::POS_W-1:0]   pa_reg [3];
    logic signed [vna_pkg::POS_W-1:0]   pb_reg [3];
    logic signed [vna_pkg::POS_W-1:0]   pc_reg [3];
    logic signed [vna_pkg::UNIT_W-1:0]  unit_reg [3];
    logic                               out_valid_reg;
    vna_pkg::result_t                   out_reg;

    logic [ADDR_W-1:0]     vi_addr;
    logic [ADDR_W-1:0]     corner_sel;
    logic [ADDR_W-1:0]     pos_raddr;
    logic                  pos_we;
    logic [POS_RAM_W-1:0]  pos_wdata;
    logic [POS_RAM_W-1:0]  pos_rdata;
    logic                  acc_we;
    logic [ADDR_W-1:0]     acc_waddr;
    logic [ACC_RAM_W-1:0]  acc_wdata;
    logic [ACC_RAM_W-1:0]  acc_rdata;
    logic [ACC_RAM_W-1:0]  acc_new;
    logic                  out_load;
    logic [24:0]           sx, sy, sz;

    vna_pkg::norm_req_t    nreq;
    vna_pkg::norm_res_t    nres;

    // {clipped, value}
    function automatic logic [24:0] sat_add(input logic signed [23:0] acc,
                                            input logic signed [15:0] add);
        logic signed [24:0] s;
        s = 25'(acc) + 25'(add);
        if (s > 25'sd8388607)
        begin
            return {1'b1, 24'h7FFFFF};
        end
        else if (s < -25'sd8388608)
        begin
            return {1'b1, 24'h800000};
        end
        return {1'b0, s[23:0]};
    endfunction

    assign vi_addr = item_reg.vertex_index[ADDR_W-1:0];

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    corner_sel = item_reg.corner_first[ADDR_W-1:0];
            2'd1:    corner_sel = item_reg.corner_second[ADDR_W-1:0];
            default: corner_sel = item_reg.corner_third[ADDR_W-1:0];
        endcase
    end

    assign pos_raddr = (item_reg.op == vna_pkg::OP_FACE) ? corner_sel : vi_addr;
    assign pos_we    = (state_reg == vna_pkg::B_EXEC) && (item_reg.op == vna_pkg::OP_WRITE);
    assign pos_wdata = {item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};

    always_comb
    begin
        sx      = sat_add(acc_rdata[23:0], unit_reg[0]);
        sy      = sat_add(acc_rdata[47:24], unit_reg[1]);
        sz      = sat_add(acc_rdata[71:48], unit_reg[2]);
        acc_new = {acc_rdata[72] | sx[24] | sy[24] | sz[24], sz[23:0], sy[23:0], sx[23:0]};
    end

    assign acc_we    = (state_reg == vna_pkg::B_CLEAR) || (state_reg == vna_pkg::B_ACC_WR);
    assign acc_waddr = (state_reg == vna_pkg::B_CLEAR) ? clr_reg : corner_sel;
    assign acc_wdata = (state_reg == vna_pkg::B_CLEAR) ? '0 : acc_new;

    vna_ram #(
        .WIDTH (POS_RAM_W),
        .DEPTH (STORE_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (vi_addr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(
        .WIDTH (ACC_RAM_W),
        .DEPTH (STORE_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (pos_raddr),
        .rdata (acc_rdata)
    );

    always_comb
    begin
        nreq.start = state_reg == vna_pkg::B_NORM_GO;
        nreq.e1x   = vna_pkg::EDGE_W'(pb_reg[0]) - vna_pkg::EDGE_W'(pa_reg[0]);
        nreq.e1y   = vna_pkg::EDGE_W'(pb_reg[1]) - vna_pkg::EDGE_W'(pa_reg[1]);
        nreq.e1z   = vna_pkg::EDGE_W'(pb_reg[2]) - vna_pkg::EDGE_W'(pa_reg[2]);
        nreq.e2x   = vna_pkg::EDGE_W'(pc_reg[0]) - vna_pkg::EDGE_W'(pa_reg[0]);
        nreq.e2y   = vna_pkg::EDGE_W'(pc_reg[1]) - vna_pkg::EDGE_W'(pa_reg[1]);
        nreq.e2z   = vna_pkg::EDGE_W'(pc_reg[2]) - vna_pkg::EDGE_W'(pa_reg[2]);
    end

    vna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .res   (nres)
    );

    assign out_load  = (state_reg == vna_pkg::B_RD_DATA) && (!out_valid_reg || out_ready);
    assign q_pop     = (state_reg == vna_pkg::B_IDLE) && q_valid;
    assign clearing  = state_reg == vna_pkg::B_CLEAR;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vna_pkg::B_CLEAR:
            begin
                if (clr_reg == LAST_ADDR) state_next = vna_pkg::B_IDLE;
            end
            vna_pkg::B_IDLE:
            begin
                if (q_valid) state_next = vna_pkg::B_EXEC;
            end
            vna_pkg::B_EXEC:
            begin
                unique case (item_reg.op)
                    vna_pkg::OP_WRITE: state_next = vna_pkg::B_IDLE;
                    vna_pkg::OP_FACE:  state_next = vna_pkg::B_FA;
                    default:           state_next = vna_pkg::B_RD_DATA;
                endcase
            end
            vna_pkg::B_RD_DATA:
            begin
                if (out_load) state_next = vna_pkg::B_IDLE;
            end
            vna_pkg::B_FA:
            begin
                if (cnt_reg == 2'd3) state_next = vna_pkg::B_NORM_GO;
            end
            vna_pkg::B_NORM_GO:   state_next = vna_pkg::B_NORM_WAIT;
            vna_pkg::B_NORM_WAIT:
            begin
                if (nres.done)
                begin
                    state_next = nres.degenerate ? vna_pkg::B_IDLE : vna_pkg::B_ACC_RD;
                end
            end
            vna_pkg::B_ACC_RD:    state_next = vna_pkg::B_ACC_WR;
            vna_pkg::B_ACC_WR:
            begin
                state_next = (cnt_reg == 2'd2) ? vna_pkg::B_IDLE : vna_pkg::B_ACC_RD;
            end
            default:              state_next = vna_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vna_pkg::B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vna_pkg::B_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            cnt_reg  <= '0;
        end
        if (state_reg == vna_pkg::B_EXEC)
        begin
            cnt_reg <= 2'd1;
        end
        if (state_reg == vna_pkg::B_FA)
        begin
            unique case (cnt_reg)
                2'd1:
                begin
                    pa_reg[0] <= pos_rdata[15:0];
                    pa_reg[1] <= pos_rdata[31:16];
                    pa_reg[2] <= pos_rdata[47:32];
                end
                2'd2:
                begin
                    pb_reg[0] <= pos_rdata[15:0];
                    pb_reg[1] <= pos_rdata[31:16];
                    pb_reg[2] <= pos_rdata[47:32];
                end
                default:
                begin
                    pc_reg[0] <= pos_rdata[15:0];
                    pc_reg[1] <= pos_rdata[31:16];
                    pc_reg[2] <= pos_rdata[47:32];
                end
            endcase
            cnt_reg <= cnt_reg + 2'd1;
        end
        if ((state_reg == vna_pkg::B_NORM_WAIT) && nres.done)
        begin
            unit_reg[0] <= nres.ux;
            unit_reg[1] <= nres.uy;
            unit_reg[2] <= nres.uz;
            cnt_reg     <= '0;
        end
        if (state_reg == vna_pkg::B_ACC_WR)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        if (out_load)
        begin
            if (item_reg.op == vna_pkg::OP_READ_ZERO)
            begin
                out_reg <= '0;
            end
            else
            begin
                out_reg <= {acc_rdata, pos_rdata};
            end
        end
    end

endmodule

### design/vertex_normal_accumulator_unit.sv
// Flow after the queue: write done in EXEC; read via EXEC and RD_DATA to the output register;
//   face reads its corners, then the normal unit: cross product, one-bit normalising shift,
//   32-step square root, three 15-step divisions (a degenerate face stops after the cross
//   product, adds nothing), accumulator RMW per corner. Items leave the queue in B_IDLE.
// Throughput: one item at a time in the back end; a 2-word queue lets input run ahead.
// Reset: asynchronous, active low; then s_tready low while min(VERTEX_COUNT, 65536) words clear.
module vertex_normal_accumulator_unit #(
    parameter int VERTEX_COUNT = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_first, corner_second, corner_third
    input  logic [vna_pkg::S_DATA_W-1:0]  s_tdata,
    // command
    input  logic [vna_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_pos_x, out_pos_y, out_pos_z, normal_x, normal_y, normal_z, saturated, zero fill
    output logic [vna_pkg::M_DATA_W-1:0]  m_tdata
);

    // only the first 65536 vertices can be addressed by a 16-bit index
    localparam int STORE_DEPTH = (VERTEX_COUNT < 65536) ? VERTEX_COUNT : 65536;

    logic              q_valid;
    vna_pkg::item_t    q_item;
    logic              q_pop;
    logic              clearing;
    vna_pkg::result_t  out_word;

    // front end: takes words, drops ignored commands, queues the rest
    vna_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back end: RAMs, normal unit, accumulator RMW and the output register
    vna_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {(vna_pkg::M_DATA_W - vna_pkg::RES_W)'(0), out_word};

endmodule

### design/vna_checker.sv
module vna_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vna_pkg::M_DATA_W-1:0]  m_tdata
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // fill bits above the saturated flag are zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[vna_pkg::M_DATA_W-1:vna_pkg::RES_W] == '0)
        else $error("fill bits set in result word");

    // accumulator clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input taken during clearing pass");

    // no result may appear in the first cycle after reset
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result word right after reset");

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
